// File: rtl/csrmv_pkg.sv
// Package: widths, request codes and stage control type for the CSR sparse mat-vec block.
`timescale 1ns / 1ps

package csrmv_pkg;

    localparam int VEC_DEPTH  = 1024;
    localparam int VEC_ADDR_W = $clog2(VEC_DEPTH);
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_NZ    = 2'd1,
        REQ_EMPTY = 2'd2
    } req_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       req;
        logic             last;
        logic [IDX_W-1:0] row;
    } stage_ctrl_t;

endpackage

// File: rtl/csr_sparse_matvec.sv
// Top level: CSR sparse matrix times dense vector, vector store, multiplier and accumulator.
// An item's result is valid once the item has passed the store-read, multiply and result registers in turn.
// Throughput: one item per cycle; the three-stage pipe (store read, 32x32 multiply,
// accumulate) holds only while a finished result waits under out_stall.
// Reset: accumulator and valid flags clear asynchronously; the vector store is not
// cleared and entries read before being written return arbitrary data.
`timescale 1ns / 1ps

module csr_sparse_matvec
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              req_type,
    input  logic [csrmv_pkg::IDX_W-1:0]             vector_index,
    input  logic signed [csrmv_pkg::DATA_W-1:0]     vector_value,
    input  logic [csrmv_pkg::IDX_W-1:0]             column,
    input  logic signed [csrmv_pkg::DATA_W-1:0]     matrix_value,
    input  logic [csrmv_pkg::IDX_W-1:0]             row_index,
    input  logic                                    last_in_row,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [csrmv_pkg::IDX_W-1:0]             out_row,
    output logic signed [csrmv_pkg::DATA_W-1:0]     row_sum
);

    logic [csrmv_pkg::DATA_W-1:0] vec_mem [csrmv_pkg::VEC_DEPTH];

    logic                                 en;
    logic                                 in_xfer;
    logic                                 wr_en;
    logic                                 wr_in_range;
    logic                                 col_in_range;

    csrmv_pkg::stage_ctrl_t               s1_ctrl_reg;
    csrmv_pkg::stage_ctrl_t               s1_ctrl_next;
    logic signed [csrmv_pkg::DATA_W-1:0]  s1_mval_reg;
    logic                                 s1_inrange_reg;
    logic signed [csrmv_pkg::DATA_W-1:0]  vec_rd_reg;

    csrmv_pkg::stage_ctrl_t               s2_ctrl_reg;
    logic signed [csrmv_pkg::ACC_W-1:0]   prod_reg;
    logic signed [csrmv_pkg::ACC_W-1:0]   prod_next;
    logic signed [csrmv_pkg::DATA_W-1:0]  vec_x;

    assign en           = !(out_valid && out_stall);
    assign in_stall     = !en;
    assign in_xfer      = in_valid && en;
    assign wr_in_range  = (32'(vector_index) < csrmv_pkg::VEC_DEPTH);
    assign col_in_range = (32'(column) < csrmv_pkg::VEC_DEPTH);
    assign wr_en        = in_xfer && (req_type == csrmv_pkg::REQ_WRITE) && wr_in_range;

    always_comb
    begin
        s1_ctrl_next.valid = in_xfer;
        s1_ctrl_next.req   = req_type;
        s1_ctrl_next.last  = last_in_row;
        s1_ctrl_next.row   = row_index;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vec_mem[csrmv_pkg::VEC_ADDR_W'(vector_index)] <= vector_value;
        end
        if (en)
        begin
            vec_rd_reg <= vec_mem[csrmv_pkg::VEC_ADDR_W'(column)];
        end
    end

    assign vec_x     = s1_inrange_reg ? vec_rd_reg : '0;
    assign prod_next = s1_mval_reg * vec_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mval_reg    <= matrix_value;
            s1_inrange_reg <= col_in_range;
            prod_reg       <= prod_next;
        end
    end

    csrmv_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctrl      (s2_ctrl_reg),
        .prod      (prod_reg),
        .res_valid (out_valid),
        .res_row   (out_row),
        .res_sum   (row_sum)
    );

endmodule

// File: rtl/csrmv_accum.sv
// Accumulate stage: shifts each product to Q16.16, saturating 64-bit sum, result register.
`timescale 1ns / 1ps

module csrmv_accum
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  csrmv_pkg::stage_ctrl_t                  ctrl,
    input  logic signed [csrmv_pkg::ACC_W-1:0]      prod,
    output logic                                    res_valid,
    output logic [csrmv_pkg::IDX_W-1:0]             res_row,
    output logic signed [csrmv_pkg::DATA_W-1:0]     res_sum
);

    localparam logic signed [csrmv_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(csrmv_pkg::ACC_W-1){1'b1}}};
    localparam logic signed [csrmv_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(csrmv_pkg::ACC_W-1){1'b0}}};
    localparam logic signed [csrmv_pkg::ACC_W-1:0] OUT_MAX =
        csrmv_pkg::ACC_W'({1'b0, {(csrmv_pkg::DATA_W-1){1'b1}}});
    localparam logic signed [csrmv_pkg::ACC_W-1:0] OUT_MIN =
        -csrmv_pkg::ACC_W'({1'b1, {(csrmv_pkg::DATA_W-1){1'b0}}});

    logic signed [csrmv_pkg::ACC_W-1:0]  acc_reg;
    logic signed [csrmv_pkg::ACC_W-1:0]  acc_next;
    logic                                res_valid_reg;
    logic                                res_valid_next;
    logic [csrmv_pkg::IDX_W-1:0]         res_row_reg;
    logic [csrmv_pkg::IDX_W-1:0]         res_row_next;
    logic signed [csrmv_pkg::DATA_W-1:0] res_sum_reg;
    logic signed [csrmv_pkg::DATA_W-1:0] res_sum_next;

    logic signed [csrmv_pkg::ACC_W-1:0]  prod_sh;
    logic signed [csrmv_pkg::ACC_W:0]    sum_wide;
    logic signed [csrmv_pkg::ACC_W-1:0]  sum_sat;
    logic signed [csrmv_pkg::DATA_W-1:0] sum_out;

    always_comb
    begin
        prod_sh  = prod >>> csrmv_pkg::FRAC_BITS;
        sum_wide = {acc_reg[csrmv_pkg::ACC_W-1], acc_reg}
                 + {prod_sh[csrmv_pkg::ACC_W-1], prod_sh};
        if (sum_wide[csrmv_pkg::ACC_W] != sum_wide[csrmv_pkg::ACC_W-1])
        begin
            sum_sat = sum_wide[csrmv_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum_sat = sum_wide[csrmv_pkg::ACC_W-1:0];
        end
        if (sum_sat > OUT_MAX)
        begin
            sum_out = OUT_MAX[csrmv_pkg::DATA_W-1:0];
        end
        else if (sum_sat < OUT_MIN)
        begin
            sum_out = OUT_MIN[csrmv_pkg::DATA_W-1:0];
        end
        else
        begin
            sum_out = sum_sat[csrmv_pkg::DATA_W-1:0];
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        res_row_next   = res_row_reg;
        res_sum_next   = res_sum_reg;
        if (en)
        begin
            res_valid_next = 1'b0;
            if (ctrl.valid)
            begin
                case (ctrl.req)
                    csrmv_pkg::REQ_NZ:
                    begin
                        if (ctrl.last)
                        begin
                            acc_next       = '0;
                            res_valid_next = 1'b1;
                            res_row_next   = ctrl.row;
                            res_sum_next   = sum_out;
                        end
                        else
                        begin
                            acc_next = sum_sat;
                        end
                    end
                    csrmv_pkg::REQ_EMPTY:
                    begin
                        res_valid_next = 1'b1;
                        res_row_next   = ctrl.row;
                        res_sum_next   = '0;
                    end
                    default:
                    begin
                        res_valid_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_row_reg <= res_row_next;
        res_sum_reg <= res_sum_next;
    end

    assign res_valid = res_valid_reg;
    assign res_row   = res_row_reg;
    assign res_sum   = res_sum_reg;

    a_last_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctrl.valid && ctrl.req == csrmv_pkg::REQ_NZ && ctrl.last) |=> (acc_reg == '0))
        else $error("accumulator not cleared after row end");

    a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctrl.valid && ctrl.req == csrmv_pkg::REQ_EMPTY)
        |=> (res_valid_reg && res_sum_reg == '0))
        else $error("empty row did not give a zero result");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctrl.valid && ctrl.req == csrmv_pkg::REQ_WRITE) |=> !res_valid_reg)
        else $error("vector write produced a result");

    a_hold_acc: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(acc_reg))
        else $error("accumulator moved while stalled");

endmodule
